// File: rtl/core/seven_segment_scan_serializer_top_assert.svh
// Assertion macros for the seven-segment scan serializer.
// Used by the top level only; the bodies are empty when SYNTH is defined.
`ifndef SEVEN_SEGMENT_SCAN_SERIALIZER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_SERIALIZER_TOP_ASSERT_SVH

`ifndef SYNTH
// checked only out of reset
`define SSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sss assertion failed");
// checked at every edge, reset included
`define SSS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sss assertion failed");
`else
`define SSS_ASSERT(lbl, prop)
`define SSS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/core/sss_pkg.sv
// Shared types, constants and the segment code table of the scan serializer.
// No dependencies.
`default_nettype none
package sss_pkg;

  localparam int unsigned NUM_W          = 16;    // number and refresh widths
  localparam int unsigned CNT_W          = 6;     // tick count / reload width
  localparam int unsigned RATE_W         = 10;    // refresh rate after range check
  localparam int unsigned REFRESH_MIN    = 50;
  localparam int unsigned REFRESH_MAX    = 1000;
  localparam int unsigned REFRESH_DFLT   = 100;
  localparam int unsigned DIV_NUMERATOR  = 46875;
  localparam int unsigned SEG_W          = 8;
  localparam int unsigned EN_W           = 4;
  localparam logic [2:0]  BIT_LAST       = 3'd7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             op;
    logic [NUM_W-1:0] value;
  } item_t;

  // reload value and the count restart from a refresh write
  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] reload;
  } rld_t;

  // active-low segment codes, common anode; codes above nine wrap modulo ten
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0, 4'd10: s = 8'hC0;
      4'd1, 4'd11: s = 8'hF9;
      4'd2, 4'd12: s = 8'hA4;
      4'd3, 4'd13: s = 8'hB0;
      4'd4, 4'd14: s = 8'h99;
      4'd5, 4'd15: s = 8'h92;
      4'd6:        s = 8'h82;
      4'd7:        s = 8'hF8;
      4'd8:        s = 8'h80;
      4'd9:        s = 8'h90;
      default:     s = 8'hC0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sss_front.sv
// Input side: unpacks a beat, saturates the number and pushes it to the queue.
// Depends on sss_pkg.
`default_nettype none
module sss_front #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [sss_pkg::NUM_W-1:0] s_axis_tdata_i,
  input  wire logic [0:0]                s_axis_tuser_i,
  input  wire logic                      q_full_i,
  input  wire logic                      hold_i,
  output logic                           push_o,
  output sss_pkg::item_t                 item_o
);
  import sss_pkg::*;

  localparam int unsigned LIMIT = 10 ** DIGIT_COUNT - 1;

  assign s_axis_tready_o = !q_full_i && !hold_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_o.op = s_axis_tuser_i[0];
    if ({16'd0, s_axis_tdata_i} > LIMIT) begin
      item_o.value = NUM_W'(LIMIT);
    end else begin
      item_o.value = s_axis_tdata_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sss_queue.sv
// Two-entry queue between the front and the back of the serializer.
// Depends on sss_pkg.
`default_nettype none
module sss_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire sss_pkg::item_t item_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output sss_pkg::item_t item_o
);
  import sss_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sss_reload.sv
// Refresh register: range check and a bit-serial divide giving the tick reload.
// Depends on sss_pkg.
`default_nettype none
module sss_reload #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [sss_pkg::NUM_W-1:0] cfg_data_i,
  output logic                           busy_o,
  output sss_pkg::rld_t                  rld_o
);
  import sss_pkg::*;

  localparam int unsigned DIV_SCALE   = 4 * DIGIT_COUNT;
  localparam int unsigned DIV_MAX     = DIV_SCALE * REFRESH_MAX;
  localparam int unsigned DIV_W       = $clog2(DIV_MAX + 1);
  localparam int unsigned STEP_W      = $clog2(NUM_W);
  localparam int unsigned RST_QUO     = DIV_NUMERATOR / (DIV_SCALE * REFRESH_DFLT);
  localparam int unsigned RST_RELOAD  = (RST_QUO < 1) ? 1 : RST_QUO;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  reload_q, reload_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DIV_W:0]    trial;
  logic              ge;
  logic [RATE_W-1:0] rate;
  logic              wr;

  assign cfg_ready_o = !busy_q;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign busy_o      = busy_q;
  assign rld_o.clear  = wr;
  assign rld_o.reload = reload_q;

  always_comb begin
    if (cfg_data_i < NUM_W'(REFRESH_MIN) || cfg_data_i > NUM_W'(REFRESH_MAX)) begin
      rate = RATE_W'(REFRESH_DFLT);
    end else begin
      rate = cfg_data_i[RATE_W-1:0];
    end
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = (trial >= {1'b0, div_q});

    busy_d   = busy_q;
    step_d   = step_q;
    reload_d = reload_q;
    div_d    = div_q;
    rem_d    = rem_q;
    num_d    = num_q;
    quo_d    = quo_q;

    if (busy_q) begin
      // restoring step: one quotient bit per cycle
      rem_d  = ge ? DIV_W'(trial - {1'b0, div_q}) : DIV_W'(trial);
      quo_d  = {quo_q[NUM_W-2:0], ge};
      num_d  = {num_q[NUM_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d   = 1'b0;
        reload_d = (quo_d == '0) ? CNT_W'(1) : quo_d[CNT_W-1:0];
      end
    end
    if (wr) begin
      busy_d = 1'b1;
      step_d = '0;
      div_d  = DIV_W'({22'd0, rate} * DIV_SCALE);
      rem_d  = '0;
      num_d  = NUM_W'(DIV_NUMERATOR);
      quo_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      reload_q <= CNT_W'(RST_RELOAD);
    end else begin
      busy_q   <= busy_d;
      step_q   <= step_d;
      reload_q <= reload_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/sss_back.sv
// Back end: digit conversion, tick counting, scan and the bit serializer.
// Depends on sss_pkg.
`default_nettype none
module sss_back #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire sss_pkg::item_t           q_item_i,
  output logic                          q_pop_o,
  input  wire sss_pkg::rld_t            rld_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          out_bit_o,
  output logic                          out_last_o,
  output logic [sss_pkg::EN_W-1:0]      out_en_o
);
  import sss_pkg::*;

  localparam int unsigned PW     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned BW     = 4 * DIGIT_COUNT;
  localparam int unsigned CONV_W = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [3:0]        digit_q [DIGIT_COUNT];
  logic [3:0]        digit_d [DIGIT_COUNT];
  logic [PW-1:0]     scan_pos_q, scan_pos_d;
  logic [PW-1:0]     en_pos_q, en_pos_d;
  logic [CNT_W-1:0]  tick_q, tick_d;
  logic [2:0]        bit_cnt_q, bit_cnt_d;
  logic [CONV_W-1:0] conv_cnt_q, conv_cnt_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic [BW-1:0]     bcd_q, bcd_d, bcd_adj;
  logic [NUM_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  reload_eff, tick_inc;
  logic              beat, last_beat, take;

  assign out_valid_o = (state_q == ST_SHIFT);
  assign out_bit_o   = seg_q[SEG_W-1];
  assign out_last_o  = out_valid_o && (bit_cnt_q == BIT_LAST);
  assign out_en_o    = out_last_o ? (EN_W'(1) << en_pos_q) : '0;

  assign beat      = out_valid_o && out_ready_i;
  assign last_beat = beat && (bit_cnt_q == BIT_LAST);
  // a new item may enter in the cycle the last bit leaves
  assign take      = (state_q == ST_IDLE) || last_beat;
  assign q_pop_o   = take && q_valid_i;

  assign reload_eff = (rld_i.reload == '0) ? CNT_W'(1) : rld_i.reload;
  assign tick_inc   = tick_q + CNT_W'(1);

  always_comb begin
    // double dabble: add three to every digit of five or more before the shift
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d    = state_q;
    digit_d    = digit_q;
    scan_pos_d = scan_pos_q;
    en_pos_d   = en_pos_q;
    tick_d     = tick_q;
    bit_cnt_d  = bit_cnt_q;
    conv_cnt_d = conv_cnt_q;
    seg_d      = seg_q;
    bcd_d      = bcd_q;
    val_d      = val_q;

    if (beat) begin
      seg_d     = {seg_q[SEG_W-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q + 3'd1;
      if (last_beat) begin
        state_d = ST_IDLE;
      end
    end

    if (state_q == ST_CONV) begin
      bcd_d      = {bcd_adj[BW-2:0], val_q[NUM_W-1]};
      val_d      = {val_q[NUM_W-2:0], 1'b0};
      conv_cnt_d = conv_cnt_q + CONV_W'(1);
      if (conv_cnt_q == CONV_W'(NUM_W - 1)) begin
        state_d = ST_IDLE;
        // digit 0 is the most significant
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digit_d[i] = bcd_d[4*(DIGIT_COUNT-1-i) +: 4];
        end
      end
    end

    if (rld_i.clear) begin
      tick_d = '0;
    end

    if (q_pop_o) begin
      if (q_item_i.op == OP_LOAD) begin
        state_d    = ST_CONV;
        bcd_d      = '0;
        val_d      = q_item_i.value;
        conv_cnt_d = '0;
      end else if (tick_inc < reload_eff) begin
        tick_d = tick_inc;
      end else begin
        tick_d     = '0;
        state_d    = ST_SHIFT;
        seg_d      = seg_code(digit_q[scan_pos_q]);
        bit_cnt_d  = '0;
        en_pos_d   = scan_pos_q;
        scan_pos_d = (scan_pos_q == PW'(DIGIT_COUNT - 1)) ? '0 : scan_pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_pos_q <= '0;
      tick_q     <= '0;
      bit_cnt_q  <= '0;
      conv_cnt_q <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      scan_pos_q <= scan_pos_d;
      tick_q     <= tick_d;
      bit_cnt_q  <= bit_cnt_d;
      conv_cnt_q <= conv_cnt_d;
      digit_q    <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    en_pos_q <= en_pos_d;
    seg_q    <= seg_d;
    bcd_q    <= bcd_d;
    val_q    <= val_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/seven_segment_scan_serializer_top.sv
// Seven-segment scan serializer: a tick that reaches the reload gives eight beats,
// one a cycle when the sink is ready; the next item enters on the last beat.
// Ticks that do not scan only step the count; a number load runs the back end's
// 16-step binary-to-decimal conversion; queue of two entries in front.
// A refresh write runs a serial divide, inputs held off meanwhile.
// Async active-low reset: digits 0, scan 0, count 0, reload from 100 Hz.
`default_nettype none
module seven_segment_scan_serializer_top #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,       // refresh_hz
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // number_value
  input  wire logic [0:0]  s_axis_tuser_i,   // operation
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // shift_data, zero fill
  output logic [3:0]       m_axis_tuser_o,   // digit_enable
  output logic             m_axis_tlast_o    // latch_pulse
);
  import sss_pkg::*;

  `include "seven_segment_scan_serializer_top_assert.svh"

  item_t push_item, q_item;
  rld_t  rld;
  logic  push, q_full, q_valid, q_pop, div_busy, out_bit;

  sss_reload #(.DIGIT_COUNT(DIGIT_COUNT)) u_reload (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .busy_o     (div_busy),
    .rld_o      (rld)
  );

  sss_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_full_i       (q_full),
    .hold_i         (div_busy),
    .push_o         (push),
    .item_o         (push_item)
  );

  sss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  sss_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .rld_i      (rld),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_bit_o  (out_bit),
    .out_last_o (m_axis_tlast_o),
    .out_en_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {7'd0, out_bit};

  // a refresh write holds off both input channels on the next cycle
  `SSS_ASSERT(a_cfg_holds_input, cfg_valid_i && cfg_ready_o |=> !s_axis_tready_o && !cfg_ready_o)
  // digit enable only with the latch beat, and at most one digit
  `SSS_ASSERT(a_enable_on_latch, m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o == 4'd0)
  `SSS_ASSERT(a_enable_onehot, m_axis_tvalid_o && m_axis_tlast_o |-> $onehot0(m_axis_tuser_o))
  // queue never written while full, never read empty
  `SSS_ASSERT_ALWAYS(a_queue_bounds, !(push && q_full) && !(q_pop && !q_valid))

endmodule
`default_nettype wire
